// ===== hw/rtl/pnl_pkg.sv =====
// Shared types, sizes and codes of the packed neighbor list table.
`timescale 1ns / 1ps
`default_nettype none

package pnl_pkg;

  // Storage sizes
  localparam int unsigned MAX_POINTS    = 4096;
  localparam int unsigned MAX_NEIGHBORS = 64;
  localparam int unsigned STORE_ENTRIES = 32768;

  // Derived index and counter widths
  localparam int unsigned PT_AW   = $clog2(MAX_POINTS);
  localparam int unsigned STG_AW  = $clog2(MAX_NEIGHBORS);
  localparam int unsigned CNT_W   = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned STO_AW  = $clog2(STORE_ENTRIES);
  localparam int unsigned WOFF_W  = $clog2(STORE_ENTRIES + 1);

  // Fixed field widths of the command and result beats
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned POINT_W = 12;
  localparam int unsigned NBR_W   = 12;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned ACT_W   = 13;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 3'd0,
    MODE_BEGIN  = 3'd1,
    MODE_ADD    = 3'd2,
    MODE_COMMIT = 3'd3,
    MODE_QUERY  = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_STAGE_FULL = 3'd1,
    STAT_STORE_FULL = 3'd2,
    STAT_RANGE      = 3'd3,
    STAT_SLOT       = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_COPY,
    S_QREC,
    S_QDAT
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [POINT_W-1:0] point_index;
    logic [NBR_W-1:0]   neighbor_index;
    logic [DIST_W-1:0]  distance_bits;
    logic [SLOT_W-1:0]  slot;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [NBR_W-1:0]  found_neighbor;
    logic [DIST_W-1:0] found_distance;
    logic [LEN_W-1:0]  list_length;
  } res_t;

  // One neighbor entry of the staging list or the shared store
  typedef struct packed {
    logic [NBR_W-1:0]  nbr;
    logic [DIST_W-1:0] dist_bits;
  } entry_t;

  // Per-point record: neighbor count and start offset in the store
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [STO_AW-1:0] off;
  } rec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/packed_neighbor_list_table_top.sv =====
// Top level of the packed neighbor list table: control, record, staging and store memories.
`timescale 1ns / 1ps
`default_nettype none

// Packed neighbor list table. A command beat is taken at a clock edge with start_i high and
// busy_o low; its one result beat comes from the result register, marked by
// res_valid_o for exactly one cycle, and cannot be stalled. Begin, add, unused modes and any
// refused or empty command answer in the cycle after acceptance and leave busy_o low, so such
// beats can be issued every cycle. A query holds busy_o through the record read (S_QREC) when the
// slot is refused, or through the record read and then the store read (S_QDAT) when it returns an
// entry. A commit answers at once and then holds busy_o while the copy loop moves one staged
// entry per cycle through the staging memory into the store. A clear answers at once and then
// holds busy_o while it zeroes all MAX_POINTS (4096) per-point records one entry per cycle;
// the same clearing pass runs after reset, so busy_o stays high until that pass ends after
// rst_ni is released. The active_points register is written through the cfg
// channel, which is always ready; write it only while the block is idle.
module packed_neighbor_list_table_top (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // command channel
  input  wire                            start_i,
  output logic                           busy_o,
  input  wire pnl_pkg::cmd_t             cmd_i,
  // result channel
  output logic                           res_valid_o,
  output pnl_pkg::res_t                  res_o,
  // configuration channel: active_points
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [pnl_pkg::ACT_W-1:0]       cfg_data_i
);

  pnl_pkg::state_e                  state_q, state_d;
  logic [pnl_pkg::ACT_W-1:0]        active_q;
  logic [pnl_pkg::CNT_W-1:0]        stg_cnt_q, stg_cnt_d;
  logic [pnl_pkg::POINT_W-1:0]      cur_pt_q, cur_pt_d;
  logic [pnl_pkg::WOFF_W-1:0]       wo_q, wo_d;
  logic [pnl_pkg::PT_AW-1:0]        sweep_q, sweep_d;
  logic [pnl_pkg::CNT_W-1:0]        idx_q, idx_d;
  logic [pnl_pkg::STO_AW-1:0]       base_q, base_d;
  logic                             pend_q, pend_d;
  logic [pnl_pkg::STO_AW-1:0]       pend_addr_q, pend_addr_d;
  logic [pnl_pkg::SLOT_W-1:0]       slot_q, slot_d;
  pnl_pkg::res_t                    res_q, res_d;
  logic                             res_valid_q, res_valid_d;

  // memory ports
  logic                             rec_we, rec_re;
  logic [pnl_pkg::PT_AW-1:0]        rec_waddr, rec_raddr;
  pnl_pkg::rec_t                    rec_wdata, rec_rdata_q;
  logic                             stg_we, stg_re;
  logic [pnl_pkg::STG_AW-1:0]       stg_waddr, stg_raddr;
  pnl_pkg::entry_t                  stg_wdata, stg_rdata_q;
  logic                             sto_re;
  logic [pnl_pkg::STO_AW-1:0]       sto_raddr;
  pnl_pkg::entry_t                  sto_rdata_q;

  pnl_pkg::rec_t   rec_mem [pnl_pkg::MAX_POINTS];
  pnl_pkg::entry_t stg_mem [pnl_pkg::MAX_NEIGHBORS];
  pnl_pkg::entry_t sto_mem [pnl_pkg::STORE_ENTRIES];

  // helper terms
  logic                             accept;
  logic                             pt_in_rng, cur_in_rng;
  logic [pnl_pkg::WOFF_W:0]         commit_end;
  logic [pnl_pkg::WOFF_W-1:0]       q_pos;

  assign busy_o      = (state_q != pnl_pkg::S_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A point is in range below active_points; 12-bit indices are always below MAX_POINTS.
  assign pt_in_rng  = ({1'b0, cmd_i.point_index} < active_q);
  assign cur_in_rng = ({1'b0, cur_pt_q} < active_q);

  // End of the store after a commit of the whole staging list
  assign commit_end = {1'b0, wo_q} + (pnl_pkg::WOFF_W + 1)'(stg_cnt_q);

  // Store position addressed by a query, from the record read last cycle
  assign q_pos = pnl_pkg::WOFF_W'(rec_rdata_q.off) + pnl_pkg::WOFF_W'(slot_q);

  always_comb begin
    state_d     = state_q;
    stg_cnt_d   = stg_cnt_q;
    cur_pt_d    = cur_pt_q;
    wo_d        = wo_q;
    sweep_d     = sweep_q;
    idx_d       = idx_q;
    base_d      = base_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    slot_d      = slot_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    res_d.list_length = pnl_pkg::LEN_W'(stg_cnt_q);

    rec_we    = 1'b0;
    rec_waddr = cur_pt_q[pnl_pkg::PT_AW-1:0];
    rec_wdata = '0;
    rec_re    = 1'b0;
    rec_raddr = cmd_i.point_index[pnl_pkg::PT_AW-1:0];
    stg_we    = 1'b0;
    stg_waddr = stg_cnt_q[pnl_pkg::STG_AW-1:0];
    stg_wdata = {cmd_i.neighbor_index, cmd_i.distance_bits};
    stg_re    = 1'b0;
    stg_raddr = idx_q[pnl_pkg::STG_AW-1:0];
    sto_re    = 1'b0;
    sto_raddr = q_pos[pnl_pkg::STO_AW-1:0];

    case (state_q)
      pnl_pkg::S_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          case (cmd_i.mode)
            pnl_pkg::MODE_CLEAR: begin
              // rewind the store and start the record clearing pass
              wo_d    = '0;
              sweep_d = '0;
              state_d = pnl_pkg::S_SWEEP;
            end
            pnl_pkg::MODE_BEGIN: begin
              if (!pt_in_rng) begin
                res_d.status = pnl_pkg::STAT_RANGE;
              end else begin
                cur_pt_d          = cmd_i.point_index;
                stg_cnt_d         = '0;
                res_d.list_length = '0;
              end
            end
            pnl_pkg::MODE_ADD: begin
              if (stg_cnt_q >= pnl_pkg::CNT_W'(pnl_pkg::MAX_NEIGHBORS)) begin
                res_d.status = pnl_pkg::STAT_STAGE_FULL;
              end else begin
                stg_we            = 1'b1;
                stg_cnt_d         = stg_cnt_q + 1'b1;
                res_d.list_length = pnl_pkg::LEN_W'(stg_cnt_q + 1'b1);
              end
            end
            pnl_pkg::MODE_COMMIT: begin
              if (stg_cnt_q == '0) begin
                res_d.status = pnl_pkg::STAT_OK;
              end else if (!cur_in_rng) begin
                res_d.status = pnl_pkg::STAT_RANGE;
              end else if (commit_end > (pnl_pkg::WOFF_W + 1)'(pnl_pkg::STORE_ENTRIES)) begin
                res_d.status = pnl_pkg::STAT_STORE_FULL;
              end else begin
                // record the point now, then copy the staged entries
                rec_we        = 1'b1;
                rec_wdata.cnt = stg_cnt_q;
                rec_wdata.off = wo_q[pnl_pkg::STO_AW-1:0];
                base_d        = wo_q[pnl_pkg::STO_AW-1:0];
                wo_d          = commit_end[pnl_pkg::WOFF_W-1:0];
                idx_d         = '0;
                state_d       = pnl_pkg::S_COPY;
              end
            end
            pnl_pkg::MODE_QUERY: begin
              if (!pt_in_rng) begin
                res_d.status = pnl_pkg::STAT_RANGE;
              end else begin
                // hold the result until the record, and for a valid slot the entry, are read
                res_valid_d = 1'b0;
                rec_re      = 1'b1;
                slot_d      = cmd_i.slot;
                state_d     = pnl_pkg::S_QREC;
              end
            end
            default: begin
              res_d.status = pnl_pkg::STAT_OK;
            end
          endcase
        end
      end

      pnl_pkg::S_SWEEP: begin
        rec_we    = 1'b1;
        rec_waddr = sweep_q;
        rec_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == pnl_pkg::PT_AW'(pnl_pkg::MAX_POINTS - 1)) begin
          state_d = pnl_pkg::S_IDLE;
        end
      end

      pnl_pkg::S_COPY: begin
        if (idx_q < stg_cnt_q) begin
          stg_re      = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = base_q + pnl_pkg::STO_AW'(idx_q);
          idx_d       = idx_q + 1'b1;
        end else begin
          // last staged entry lands in the store at this edge
          state_d = pnl_pkg::S_IDLE;
        end
      end

      pnl_pkg::S_QREC: begin
        res_d.list_length = pnl_pkg::LEN_W'(rec_rdata_q.cnt);
        if ((pnl_pkg::CNT_W'(slot_q) >= rec_rdata_q.cnt) ||
            (q_pos >= pnl_pkg::WOFF_W'(pnl_pkg::STORE_ENTRIES))) begin
          res_valid_d  = 1'b1;
          res_d.status = pnl_pkg::STAT_SLOT;
          state_d      = pnl_pkg::S_IDLE;
        end else begin
          sto_re  = 1'b1;
          state_d = pnl_pkg::S_QDAT;
        end
      end

      pnl_pkg::S_QDAT: begin
        res_valid_d          = 1'b1;
        res_d.status         = pnl_pkg::STAT_OK;
        res_d.found_neighbor = sto_rdata_q.nbr;
        res_d.found_distance = sto_rdata_q.dist_bits;
        res_d.list_length    = pnl_pkg::LEN_W'(rec_rdata_q.cnt);
        state_d              = pnl_pkg::S_IDLE;
      end

      default: begin
        state_d = pnl_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers; the clearing pass runs right after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pnl_pkg::S_SWEEP;
      active_q    <= '0;
      stg_cnt_q   <= '0;
      cur_pt_q    <= '0;
      wo_q        <= '0;
      sweep_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stg_cnt_q   <= stg_cnt_d;
      cur_pt_q    <= cur_pt_d;
      wo_q        <= wo_d;
      sweep_q     <= sweep_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    pend_addr_q <= pend_addr_d;
    slot_q      <= slot_d;
    res_q       <= res_d;
  end

  // Per-point record memory
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (rec_re) begin
      rec_rdata_q <= rec_mem[rec_raddr];
    end
  end

  // Staging memory
  always_ff @(posedge clk_i) begin
    if (stg_we) begin
      stg_mem[stg_waddr] <= stg_wdata;
    end
    if (stg_re) begin
      stg_rdata_q <= stg_mem[stg_raddr];
    end
  end

  // Shared store: written by the copy loop, read by queries
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      sto_mem[pend_addr_q] <= stg_rdata_q;
    end
    if (sto_re) begin
      sto_rdata_q <= sto_mem[sto_raddr];
    end
  end

`ifndef SYNTH
  a_stg_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_cnt_q <= pnl_pkg::CNT_W'(pnl_pkg::MAX_NEIGHBORS))
    else $error("staging count beyond list depth");

  a_wo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wo_q <= pnl_pkg::WOFF_W'(pnl_pkg::STORE_ENTRIES))
    else $error("write offset beyond store size");

  a_query_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i.mode == pnl_pkg::MODE_QUERY) && !pt_in_rng)
    |=> (res_valid_o && (res_o.status == pnl_pkg::STAT_RANGE)))
    else $error("out-of-range query not answered next cycle");
`endif

endmodule

`default_nettype wire
